/* src/gregorian_date_arithmetic_defines.svh */
// assertion macros used by the checker file
`ifndef GREGORIAN_DATE_ARITHMETIC_DEFINES_SVH
`define GREGORIAN_DATE_ARITHMETIC_DEFINES_SVH

// same-cycle implication, muted while reset is low
`define GDA_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("date unit check failed");

// next-cycle implication, muted while reset is low
`define GDA_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("date unit check failed");

`endif

/* src/gda_pkg.sv */
package gda_pkg;

    localparam int MAX_YEAR = 9999;

    localparam int DAY_W    = 23;
    localparam int DIFF_W   = 23;
    localparam int S_DATA_W = 72;
    localparam int M_DATA_W = 56;

    // chunk sizes used by the stepping passes
    localparam logic [DAY_W-1:0] YEARS_400 = DAY_W'(400);
    localparam logic [DAY_W-1:0] YEARS_100 = DAY_W'(100);
    localparam logic [DAY_W-1:0] YEARS_4   = DAY_W'(4);
    localparam logic [DAY_W-1:0] YEARS_1   = DAY_W'(1);
    localparam logic [DAY_W-1:0] DAYS_400Y = DAY_W'(146097);
    localparam logic [DAY_W-1:0] DAYS_100Y = DAY_W'(36524);
    localparam logic [DAY_W-1:0] DAYS_4Y   = DAY_W'(1461);
    localparam logic [DAY_W-1:0] DAYS_1Y   = DAY_W'(365);

    localparam logic signed [DIFF_W:0] DIFF_MAX = (DIFF_W+1)'(4194303);
    localparam logic signed [DIFF_W:0] DIFF_MIN = -(DIFF_W+1)'(4194304);

    typedef enum logic [3:0] {
        S_IDLE,
        S_Y400,
        S_Y100,
        S_Y4,
        S_Y1,
        S_DMON,
        S_CALC,
        S_F400,
        S_F100,
        S_F4,
        S_F1,
        S_FMON,
        S_OUT
    } gda_state_t;

    typedef struct packed {
        logic             ge;
        logic [DAY_W-1:0] diff;
    } gda_cs_t;

    function automatic logic leap_const(int y);
        return (y % 400 == 0) || ((y % 4 == 0) && (y % 100 != 0));
    endfunction

    // day number of 31.12 of year y, counted from 1.1.0001
    function automatic int dec31_number(int y);
        int p;
        p = y - 1;
        return 365 * p + p / 4 - p / 100 + p / 400 + 364 + (leap_const(y) ? 1 : 0);
    endfunction

    localparam logic [DAY_W:0] LAST_DAY = (DAY_W+1)'(dec31_number(MAX_YEAR));

    function automatic logic [4:0] month_len(logic [3:0] m, logic leap);
        logic [4:0] len;
        case (m)
            4'd2:                    len = leap ? 5'd29 : 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
            4'd1, 4'd3, 4'd5, 4'd7,
            4'd8, 4'd10, 4'd12:      len = 5'd31;
            default:                 len = 5'd0;
        endcase
        return len;
    endfunction

    // days before the first of month m in a common year
    function automatic logic [8:0] days_before(logic [3:0] m);
        logic [8:0] n;
        case (m)
            4'd2:    n = 9'd31;
            4'd3:    n = 9'd59;
            4'd4:    n = 9'd90;
            4'd5:    n = 9'd120;
            4'd6:    n = 9'd151;
            4'd7:    n = 9'd181;
            4'd8:    n = 9'd212;
            4'd9:    n = 9'd243;
            4'd10:   n = 9'd273;
            4'd11:   n = 9'd304;
            4'd12:   n = 9'd334;
            default: n = 9'd0;
        endcase
        return n;
    endfunction

endpackage

/* src/gda_cmp_sub.sv */
module gda_cmp_sub (
    input  logic [gda_pkg::DAY_W-1:0] a,
    input  logic [gda_pkg::DAY_W-1:0] b,
    output gda_pkg::gda_cs_t          res
);
    import gda_pkg::*;

    logic [DAY_W:0] wide;

    // borrow out of the subtraction gives the compare
    assign wide     = {1'b0, a} - {1'b0, b};
    assign res.ge   = ~wide[DAY_W];
    assign res.diff = wide[DAY_W-1:0];

endmodule

/* src/gregorian_date_arithmetic.sv */
// Gregorian date unit.
// Input channel s_*: one item per command. s_tuser is the command (0 add day_count to
// the first date, 1 signed days from the first date to the second); s_tdata holds both
// dates and the day count. Result channel m_*: one item per input item, in order.
// An item is worked on by a single compare-subtract unit under a small sequencer:
// each date is turned into a day number by stepping off 400-, 100-, 4- and 1-year
// chunks and adding the month offset, and an add result is turned back into a date by
// the same stepping plus up to eleven month steps.
// How long an item takes depends on the number of chunk steps through the compare-subtract
// unit; the block takes one item at a time and accepts the next only once it is idle again.
// s_tready is high only while the sequencer is idle.
// If the receiver stalls, the result waits in the output register and the next item
// is processed; it is held at the end until the output register is free.
// Reset (aresetn low at a clock edge) drops m_tvalid and returns the sequencer to idle.
module gregorian_date_arithmetic (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // first_day, first_month, first_year, second_day, second_month, second_year,
    // day_count, zero fill
    input  logic [gda_pkg::S_DATA_W-1:0]   s_tdata,
    // cmd
    input  logic                           s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // result_day, result_month, result_year, day_difference, first_valid,
    // second_valid, overflow, zero fill
    output logic [gda_pkg::M_DATA_W-1:0]   m_tdata
);
    import gda_pkg::*;

    gda_state_t state_reg, state_next;

    logic              cmd_reg, cmd_next;
    logic [4:0]        d1_reg, d1_next, d2_reg, d2_next;
    logic [3:0]        m1_reg, m1_next, m2_reg, m2_next;
    logic [13:0]       y1_reg, y1_next, y2_reg, y2_next;
    logic [19:0]       cnt_reg, cnt_next;
    logic              sel_reg, sel_next;
    logic [DAY_W-1:0]  rem_reg, rem_next;
    logic [DAY_W-1:0]  acc_reg, acc_next;
    logic [4:0]        step_reg, step_next;
    logic              f400_reg, f400_next, f100_reg, f100_next;
    logic              c3_reg, c3_next, q4top_reg, q4top_next;
    logic              leap_reg, leap_next;
    logic [3:0]        mon_reg, mon_next;
    logic [DAY_W-1:0]  n1_reg, n1_next, n2_reg, n2_next;
    logic              v1_reg, v1_next, v2_reg, v2_next;
    logic [4:0]        rday_reg, rday_next;
    logic [3:0]        rmon_reg, rmon_next;
    logic [13:0]       ryear_reg, ryear_next;
    logic [DIFF_W-1:0] diff_reg, diff_next;
    logic              ovf_reg, ovf_next;
    logic              m_tvalid_reg, m_tvalid_next;
    logic [M_DATA_W-1:0] m_tdata_reg, m_tdata_next;

    logic              s_acc;
    logic              out_free;
    logic [DAY_W-1:0]  sub_b;
    gda_cs_t           cs;

    logic [4:0]        cur_d;
    logic [3:0]        cur_m;
    logic [13:0]       cur_y;
    logic              cur_leap;
    logic [4:0]        cur_len;
    logic              cur_valid;
    logic [DAY_W-1:0]  cur_number;
    logic [DAY_W:0]    add_sum;
    logic signed [DIFF_W:0] diff_wide;
    logic [4:0]        fmon_len;

    assign s_tready = (state_reg == S_IDLE);
    assign s_acc    = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // date of the current day-number pass
    assign cur_d = sel_reg ? d2_reg : d1_reg;
    assign cur_m = sel_reg ? m2_reg : m1_reg;
    assign cur_y = sel_reg ? y2_reg : y1_reg;

    assign cur_leap  = f400_reg || ((cur_y[1:0] == 2'b00) && !f100_reg);
    assign cur_len   = month_len(cur_m, cur_leap);
    assign cur_valid = (cur_y >= 14'd1) && (cur_y <= 14'(MAX_YEAR))
                    && (cur_m >= 4'd1) && (cur_m <= 4'd12)
                    && (cur_d >= 5'd1) && (cur_d <= cur_len);
    assign cur_number = acc_reg + DAY_W'(days_before(cur_m))
                      + DAY_W'(cur_leap && (cur_m > 4'd2)) + DAY_W'(cur_d) - DAY_W'(1);

    assign add_sum   = {1'b0, n1_reg} + (DAY_W+1)'(cnt_reg);
    assign diff_wide = $signed({1'b0, n2_reg}) - $signed({1'b0, n1_reg});
    assign fmon_len  = month_len(mon_reg, leap_reg);

    always_comb begin
        case (state_reg)
            S_Y400:  sub_b = YEARS_400;
            S_Y100:  sub_b = YEARS_100;
            S_Y4:    sub_b = YEARS_4;
            S_Y1:    sub_b = YEARS_1;
            S_F400:  sub_b = DAYS_400Y;
            S_F100:  sub_b = DAYS_100Y;
            S_F4:    sub_b = DAYS_4Y;
            S_F1:    sub_b = DAYS_1Y;
            S_FMON:  sub_b = DAY_W'(fmon_len);
            default: sub_b = '0;
        endcase
    end

    gda_cmp_sub u_cmp_sub (
        .a   (rem_reg),
        .b   (sub_b),
        .res (cs)
    );

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: if (s_acc) state_next = S_Y400;
            S_Y400: if (!cs.ge) state_next = S_Y100;
            S_Y100: if (!cs.ge) state_next = S_Y4;
            S_Y4:   if (!cs.ge) state_next = S_Y1;
            S_Y1:   if (!cs.ge) state_next = S_DMON;
            S_DMON: state_next = sel_reg ? S_CALC : S_Y400;
            S_CALC: begin
                if (cmd_reg || !v1_reg || (add_sum > LAST_DAY)) begin
                    state_next = S_OUT;
                end else begin
                    state_next = S_F400;
                end
            end
            S_F400: if (!cs.ge) state_next = S_F100;
            S_F100: if (!(cs.ge && (step_reg < 5'd3))) state_next = S_F4;
            S_F4:   if (!cs.ge) state_next = S_F1;
            S_F1:   if (!(cs.ge && (step_reg < 5'd3))) state_next = S_FMON;
            S_FMON: if (!(cs.ge && (mon_reg < 4'd12))) state_next = S_OUT;
            S_OUT:  if (out_free) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    // datapath
    always_comb begin
        cmd_next   = cmd_reg;
        d1_next    = d1_reg;
        m1_next    = m1_reg;
        y1_next    = y1_reg;
        d2_next    = d2_reg;
        m2_next    = m2_reg;
        y2_next    = y2_reg;
        cnt_next   = cnt_reg;
        sel_next   = sel_reg;
        rem_next   = rem_reg;
        acc_next   = acc_reg;
        step_next  = step_reg;
        f400_next  = f400_reg;
        f100_next  = f100_reg;
        c3_next    = c3_reg;
        q4top_next = q4top_reg;
        leap_next  = leap_reg;
        mon_next   = mon_reg;
        n1_next    = n1_reg;
        n2_next    = n2_reg;
        v1_next    = v1_reg;
        v2_next    = v2_reg;
        rday_next  = rday_reg;
        rmon_next  = rmon_reg;
        ryear_next = ryear_reg;
        diff_next  = diff_reg;
        ovf_next   = ovf_reg;
        m_tdata_next  = m_tdata_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;

        case (state_reg)
            S_IDLE: begin
                if (s_acc) begin
                    cmd_next = s_tuser;
                    d1_next  = s_tdata[4:0];
                    m1_next  = s_tdata[8:5];
                    y1_next  = s_tdata[22:9];
                    d2_next  = s_tdata[27:23];
                    m2_next  = s_tdata[31:28];
                    y2_next  = s_tdata[45:32];
                    cnt_next = s_tdata[65:46];
                    sel_next = 1'b0;
                    // year zero wraps to a large count, harmless since it is invalid
                    rem_next = DAY_W'(14'(s_tdata[22:9] - 14'd1));
                    acc_next = '0;
                end
            end
            S_Y400: begin
                if (cs.ge) begin
                    rem_next = cs.diff;
                    acc_next = acc_reg + DAYS_400Y;
                end else begin
                    f400_next = (rem_reg == DAY_W'(399));
                end
            end
            S_Y100: begin
                if (cs.ge) begin
                    rem_next = cs.diff;
                    acc_next = acc_reg + DAYS_100Y;
                end else begin
                    f100_next = (rem_reg == DAY_W'(99));
                end
            end
            S_Y4: begin
                if (cs.ge) begin
                    rem_next = cs.diff;
                    acc_next = acc_reg + DAYS_4Y;
                end
            end
            S_Y1: begin
                if (cs.ge) begin
                    rem_next = cs.diff;
                    acc_next = acc_reg + DAYS_1Y;
                end
            end
            S_DMON: begin
                if (sel_reg) begin
                    n2_next = cur_number;
                    v2_next = cur_valid;
                end else begin
                    n1_next  = cur_number;
                    v1_next  = cur_valid;
                    sel_next = 1'b1;
                    rem_next = DAY_W'(14'(y2_reg - 14'd1));
                    acc_next = '0;
                end
            end
            S_CALC: begin
                rday_next  = d1_reg;
                rmon_next  = m1_reg;
                ryear_next = y1_reg;
                diff_next  = '0;
                ovf_next   = 1'b0;
                if (cmd_reg) begin
                    if (v1_reg && v2_reg) begin
                        if (diff_wide > DIFF_MAX) begin
                            diff_next = DIFF_MAX[DIFF_W-1:0];
                        end else if (diff_wide < DIFF_MIN) begin
                            diff_next = DIFF_MIN[DIFF_W-1:0];
                        end else begin
                            diff_next = diff_wide[DIFF_W-1:0];
                        end
                    end
                end else if (v1_reg) begin
                    if (add_sum > LAST_DAY) begin
                        rday_next  = 5'd31;
                        rmon_next  = 4'd12;
                        ryear_next = 14'(MAX_YEAR);
                        ovf_next   = 1'b1;
                    end else begin
                        rem_next  = add_sum[DAY_W-1:0];
                        acc_next  = DAY_W'(1);
                        step_next = '0;
                    end
                end
            end
            S_F400: begin
                if (cs.ge) begin
                    rem_next = cs.diff;
                    acc_next = acc_reg + YEARS_400;
                end
            end
            S_F100: begin
                // century count is capped at three
                if (cs.ge && (step_reg < 5'd3)) begin
                    rem_next  = cs.diff;
                    acc_next  = acc_reg + YEARS_100;
                    step_next = step_reg + 5'd1;
                end else begin
                    c3_next   = (step_reg == 5'd3);
                    step_next = '0;
                end
            end
            S_F4: begin
                if (cs.ge) begin
                    rem_next  = cs.diff;
                    acc_next  = acc_reg + YEARS_4;
                    step_next = step_reg + 5'd1;
                end else begin
                    q4top_next = (step_reg == 5'd24);
                    step_next  = '0;
                end
            end
            S_F1: begin
                if (cs.ge && (step_reg < 5'd3)) begin
                    rem_next  = cs.diff;
                    acc_next  = acc_reg + YEARS_1;
                    step_next = step_reg + 5'd1;
                end else begin
                    // fourth year of a cycle is leap unless it closes a plain century
                    leap_next = (step_reg == 5'd3) && (!q4top_reg || c3_reg);
                    mon_next  = 4'd1;
                end
            end
            S_FMON: begin
                if (cs.ge && (mon_reg < 4'd12)) begin
                    rem_next = cs.diff;
                    mon_next = mon_reg + 4'd1;
                end else begin
                    rday_next  = rem_reg[4:0] + 5'd1;
                    rmon_next  = mon_reg;
                    ryear_next = acc_reg[13:0];
                end
            end
            S_OUT: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {7'b0, ovf_reg, v2_reg, v1_reg, diff_reg,
                                     ryear_reg, rmon_reg, rday_reg};
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cmd_reg     <= cmd_next;
        d1_reg      <= d1_next;
        m1_reg      <= m1_next;
        y1_reg      <= y1_next;
        d2_reg      <= d2_next;
        m2_reg      <= m2_next;
        y2_reg      <= y2_next;
        cnt_reg     <= cnt_next;
        sel_reg     <= sel_next;
        rem_reg     <= rem_next;
        acc_reg     <= acc_next;
        step_reg    <= step_next;
        f400_reg    <= f400_next;
        f100_reg    <= f100_next;
        c3_reg      <= c3_next;
        q4top_reg   <= q4top_next;
        leap_reg    <= leap_next;
        mon_reg     <= mon_next;
        n1_reg      <= n1_next;
        n2_reg      <= n2_next;
        v1_reg      <= v1_next;
        v2_reg      <= v2_next;
        rday_reg    <= rday_next;
        rmon_reg    <= rmon_next;
        ryear_reg   <= ryear_next;
        diff_reg    <= diff_next;
        ovf_reg     <= ovf_next;
        m_tdata_reg <= m_tdata_next;
    end

endmodule

/* src/gda_checker.sv */
`include "gregorian_date_arithmetic_defines.svh"

module gda_checker (
    input logic                         aclk,
    input logic                         aresetn,
    input logic                         s_tvalid,
    input logic                         s_tready,
    input logic                         m_tvalid,
    input logic                         m_tready,
    input logic [gda_pkg::M_DATA_W-1:0] m_tdata
);
    import gda_pkg::*;

    // one item at a time: busy right after an accept
    `GDA_ASSERT_NEXT(a_busy_after_accept, aclk, aresetn, s_tvalid && s_tready, !s_tready)

    // saturated add always shows the last day of the maximum year
    `GDA_ASSERT_NOW(a_ovf_saturates, aclk, aresetn, m_tvalid && m_tdata[48], (m_tdata[4:0] == 5'd31) && (m_tdata[8:5] == 4'd12) && (m_tdata[22:9] == 14'(MAX_YEAR)))

    // a nonzero difference needs two valid dates
    `GDA_ASSERT_NOW(a_diff_needs_valid, aclk, aresetn, m_tvalid && (m_tdata[45:23] != 23'd0), m_tdata[46] && m_tdata[47])

    `GDA_ASSERT_NEXT(a_m_valid_holds, aclk, aresetn, m_tvalid && !m_tready, m_tvalid)

    `GDA_ASSERT_NEXT(a_m_data_holds, aclk, aresetn, m_tvalid && !m_tready, $stable(m_tdata))

endmodule

bind gregorian_date_arithmetic gda_checker u_gda_checker (.*);

/* tb/sv/tb_gregorian_date_arithmetic.sv */
`timescale 1ns / 1ps

module tb_gregorian_date_arithmetic;
    import gda_pkg::*;

    localparam logic CMD_ADD  = 1'b0;
    localparam logic CMD_DIFF = 1'b1;

    localparam int RANDOM_ITEMS = 115;
    localparam int CYCLE_LIMIT  = 500000;
    localparam int DRAIN_CYCLES = 400;

    localparam longint SPAN_MAX = 4194303;
    localparam longint SPAN_MIN = -4194304;

    typedef struct packed {
        logic        cmd;
        logic [4:0]  first_day;
        logic [3:0]  first_month;
        logic [13:0] first_year;
        logic [4:0]  second_day;
        logic [3:0]  second_month;
        logic [13:0] second_year;
        logic [19:0] day_count;
    } date_cmd_t;

    typedef struct packed {
        logic [4:0]  result_day;
        logic [3:0]  result_month;
        logic [13:0] result_year;
        logic [22:0] day_difference;
        logic        first_valid;
        logic        second_valid;
        logic        overflow;
    } date_result_t;

    logic                aclk     = 1'b0;
    logic                aresetn  = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata  = '0;
    logic                s_tuser  = 1'b0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;

    date_cmd_t    cmd_queue[$];
    date_result_t pending_results[$];
    date_cmd_t    cur_item;
    bit           mismatch_seen = 1'b0;
    int           total_items = 0;
    int           items_sent = 0;
    int           items_accepted = 0;
    int           tx_idle = 0;
    int           rx_idle = 0;
    int           cycle_count = 0;

    gregorian_date_arithmetic DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // ---------------- calendar predictor ----------------

    function automatic bit is_leap(longint y);
        return (y % 400 == 0) || (y % 4 == 0 && y % 100 != 0);
    endfunction

    function automatic longint days_in_month(longint m, longint y);
        if (m == 2) return is_leap(y) ? 29 : 28;
        if (m == 4 || m == 6 || m == 9 || m == 11) return 30;
        if (m >= 1 && m <= 12) return 31;
        return 0;
    endfunction

    function automatic bit valid_date(longint d, longint m, longint y);
        if (y < 1 || y > MAX_YEAR || m < 1 || m > 12) return 1'b0;
        return d >= 1 && d <= days_in_month(m, y);
    endfunction

    // days since 1.1.0001
    function automatic longint ordinal_of(longint d, longint m, longint y);
        longint p;
        longint n;
        p = y - 1;
        n = 365 * p + p / 4 - p / 100 + p / 400;
        for (longint k = 1; k < m; k++) n += days_in_month(k, y);
        return n + d - 1;
    endfunction

    // returns {year, month, day}
    function automatic logic [22:0] date_of_ordinal(longint n);
        longint q400, r, c, q4, yr, y, mm;
        q400 = n / 146097;
        r    = n % 146097;
        c    = r / 36524;
        if (c > 3) c = 3;
        r  -= c * 36524;
        q4  = r / 1461;
        r   = r % 1461;
        yr  = r / 365;
        if (yr > 3) yr = 3;
        r  -= yr * 365;
        y   = 1 + 400 * q400 + 100 * c + 4 * q4 + yr;
        mm  = 1;
        while (mm < 12 && r >= days_in_month(mm, y)) begin
            r -= days_in_month(mm, y);
            mm++;
        end
        return {y[13:0], mm[3:0], 5'(r + 1)};
    endfunction

    function automatic date_result_t predict_date_op(date_cmd_t c);
        date_result_t r;
        longint       n;
        longint       span;
        r.first_valid    = valid_date(c.first_day, c.first_month, c.first_year);
        r.second_valid   = valid_date(c.second_day, c.second_month, c.second_year);
        r.result_day     = c.first_day;
        r.result_month   = c.first_month;
        r.result_year    = c.first_year;
        r.day_difference = '0;
        r.overflow       = 1'b0;
        if (c.cmd == CMD_ADD) begin
            if (r.first_valid) begin
                n = ordinal_of(c.first_day, c.first_month, c.first_year) + c.day_count;
                if (n > ordinal_of(31, 12, MAX_YEAR)) begin
                    r.result_day   = 5'd31;
                    r.result_month = 4'd12;
                    r.result_year  = 14'(MAX_YEAR);
                    r.overflow     = 1'b1;
                end else begin
                    {r.result_year, r.result_month, r.result_day} = date_of_ordinal(n);
                end
            end
        end else if (r.first_valid && r.second_valid) begin
            span = ordinal_of(c.second_day, c.second_month, c.second_year)
                 - ordinal_of(c.first_day, c.first_month, c.first_year);
            if (span > SPAN_MAX) span = SPAN_MAX;
            if (span < SPAN_MIN) span = SPAN_MIN;
            r.day_difference = span[22:0];
        end
        return r;
    endfunction

    // ---------------- stimulus helpers ----------------

    function automatic date_cmd_t date_cmd(logic cmd, int d1, int m1, int y1,
                                           int d2, int m2, int y2, int cnt);
        date_cmd_t c;
        c.cmd          = cmd;
        c.first_day    = 5'(d1);
        c.first_month  = 4'(m1);
        c.first_year   = 14'(y1);
        c.second_day   = 5'(d2);
        c.second_month = 4'(m2);
        c.second_year  = 14'(y2);
        c.day_count    = 20'(cnt);
        return c;
    endfunction

    // {year, month, day} of a valid date, biased toward century, leap and edge years
    function automatic logic [22:0] rand_valid_ymd();
        logic [13:0] y;
        logic [3:0]  m;
        logic [4:0]  d;
        int          len;
        case ($urandom_range(3))
            0: y = 14'($urandom_range(MAX_YEAR, 1));
            1: y = $urandom_range(1) ? 14'($urandom_range(5, 1))
                                     : 14'($urandom_range(MAX_YEAR, MAX_YEAR - 9));
            2: y = 14'(100 * $urandom_range(MAX_YEAR / 100, 1));
            default: y = 14'(4 * $urandom_range(MAX_YEAR / 4, 1));
        endcase
        m   = 4'($urandom_range(12, 1));
        len = int'(days_in_month(m, y));
        case ($urandom_range(3))
            0, 1: d = 5'($urandom_range(len, 1));
            2:    d = 5'(len);
            default: d = 5'd1;
        endcase
        return {y, m, d};
    endfunction

    task automatic check_field(string name, longint exp_val, longint got_val);
        if (exp_val != got_val) begin
            $error("%s: expected %0d, got %0d", name, exp_val, got_val);
            mismatch_seen = 1'b1;
        end
    endtask

    // ---------------- driver ----------------

    always @(negedge aclk) begin
        if (items_sent < total_items / 3) begin
            tx_idle = 11;
            rx_idle = 72;
        end else if (items_sent < 2 * total_items / 3) begin
            tx_idle = 72;
            rx_idle = 11;
        end else begin
            tx_idle = 0;
            rx_idle = 0;
        end
        m_tready <= aresetn && ($urandom_range(99) >= rx_idle);
        // no item outstanding once every sent item has been accepted
        if (aresetn && (items_accepted == items_sent)) begin
            if (cmd_queue.size() > 0 && $urandom_range(99) >= tx_idle) begin
                cur_item = cmd_queue.pop_front();
                items_sent++;
                s_tvalid <= 1'b1;
                s_tuser  <= cur_item.cmd;
                s_tdata  <= {6'b0, cur_item.day_count, cur_item.second_year,
                             cur_item.second_month, cur_item.second_day,
                             cur_item.first_year, cur_item.first_month,
                             cur_item.first_day};
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // ---------------- monitor ----------------

    always @(posedge aclk) begin
        date_result_t exp_r;
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
        if (aresetn && s_tvalid && s_tready) begin
            pending_results.push_back(predict_date_op(cur_item));
            items_accepted++;
        end
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                $error("result item with no expectation waiting");
                mismatch_seen = 1'b1;
            end else begin
                exp_r = pending_results.pop_front();
                check_field("result_day", exp_r.result_day, m_tdata[4:0]);
                check_field("result_month", exp_r.result_month, m_tdata[8:5]);
                check_field("result_year", exp_r.result_year, m_tdata[22:9]);
                check_field("day_difference", $signed(exp_r.day_difference),
                            $signed(m_tdata[45:23]));
                check_field("first_valid", exp_r.first_valid, m_tdata[46]);
                check_field("second_valid", exp_r.second_valid, m_tdata[47]);
                check_field("overflow", exp_r.overflow, m_tdata[48]);
            end
        end
    end

    // ---------------- stimulus and end of run ----------------

    initial begin
        date_cmd_t   c;
        date_cmd_t   t;
        logic [22:0] ymd;
        int          len;

        // directed: extremes, leap rules, invalid operands, saturation
        cmd_queue.push_back(date_cmd(CMD_ADD, 1, 1, 1, 1, 1, 1, 0));
        cmd_queue.push_back(date_cmd(CMD_ADD, 31, 12, MAX_YEAR, 1, 1, 1, 1));
        cmd_queue.push_back(date_cmd(CMD_ADD, 31, 12, MAX_YEAR, 1, 1, 1, 0));
        cmd_queue.push_back(date_cmd(CMD_ADD, 28, 2, 2000, 1, 1, 1, 1));
        cmd_queue.push_back(date_cmd(CMD_ADD, 28, 2, 1900, 1, 1, 1, 1));
        cmd_queue.push_back(date_cmd(CMD_ADD, 28, 2, 2004, 1, 1, 1, 1));
        cmd_queue.push_back(date_cmd(CMD_ADD, 1, 1, 2000, 1, 1, 1, 366));
        cmd_queue.push_back(date_cmd(CMD_ADD, 31, 12, 1999, 1, 1, 1, 1));
        cmd_queue.push_back(date_cmd(CMD_ADD, 1, 1, 1, 1, 1, 1, 1048575));
        cmd_queue.push_back(date_cmd(CMD_ADD, 1, 1, 9000, 1, 1, 1, 1048575));
        cmd_queue.push_back(date_cmd(CMD_ADD, 29, 2, 1900, 1, 1, 1, 10));
        cmd_queue.push_back(date_cmd(CMD_ADD, 0, 5, 2020, 1, 1, 1, 10));
        cmd_queue.push_back(date_cmd(CMD_ADD, 1, 13, 2020, 1, 1, 1, 10));
        cmd_queue.push_back(date_cmd(CMD_ADD, 1, 1, 0, 1, 1, 1, 10));
        cmd_queue.push_back(date_cmd(CMD_ADD, 1, 1, MAX_YEAR + 1, 1, 1, 1, 10));
        cmd_queue.push_back(date_cmd(CMD_ADD, 31, 15, 16383, 31, 15, 16383, 1048575));
        cmd_queue.push_back(date_cmd(CMD_ADD, 15, 6, 2024, 31, 9, 2024, 100));
        cmd_queue.push_back(date_cmd(CMD_DIFF, 1, 1, 1, 31, 12, MAX_YEAR, 0));
        cmd_queue.push_back(date_cmd(CMD_DIFF, 31, 12, MAX_YEAR, 1, 1, 1, 0));
        cmd_queue.push_back(date_cmd(CMD_DIFF, 10, 10, 1010, 10, 10, 1010, 1048575));
        cmd_queue.push_back(date_cmd(CMD_DIFF, 28, 2, 2000, 1, 3, 2000, 0));
        cmd_queue.push_back(date_cmd(CMD_DIFF, 1, 1, 2000, 29, 2, 2100, 0));
        cmd_queue.push_back(date_cmd(CMD_DIFF, 31, 4, 2020, 1, 1, 2000, 0));
        cmd_queue.push_back(date_cmd(CMD_DIFF, 0, 0, 0, 31, 15, 16383, 1048575));
        cmd_queue.push_back(date_cmd(CMD_DIFF, 1, 3, 1900, 28, 2, 1900, 5));

        // random: mostly valid date pairs, some raw noise, some single broken fields
        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            c.cmd = 1'($urandom_range(1));
            ymd = rand_valid_ymd();
            {c.first_year, c.first_month, c.first_day} = ymd;
            ymd = rand_valid_ymd();
            {c.second_year, c.second_month, c.second_day} = ymd;
            case ($urandom_range(2))
                0: c.day_count = 20'($urandom_range(400));
                1: c.day_count = 20'($urandom_range(40000));
                default: c.day_count = 20'($urandom);
            endcase
            len = $urandom_range(99);
            if (len >= 85) begin
                c = date_cmd_t'(67'({$urandom, $urandom, $urandom}));
            end else if (len >= 70) begin
                case ($urandom_range(3))
                    0: c.first_day = 5'd0;
                    1: begin
                        c.first_month = 4'd2;
                        c.first_day   = 5'($urandom_range(31, 30));
                    end
                    2: c.first_month = $urandom_range(1) ? 4'd0 : 4'($urandom_range(15, 13));
                    default: c.first_year = $urandom_range(1) ? 14'd0
                                          : 14'($urandom_range(16383, MAX_YEAR + 1));
                endcase
                if ($urandom_range(1)) begin
                    t = c;
                    c.first_day    = t.second_day;
                    c.first_month  = t.second_month;
                    c.first_year   = t.second_year;
                    c.second_day   = t.first_day;
                    c.second_month = t.first_month;
                    c.second_year  = t.first_year;
                end
            end
            cmd_queue.push_back(c);
        end
        total_items = cmd_queue.size();

        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        while (items_accepted < total_items || pending_results.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (!mismatch_seen && pending_results.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
